>>> sv/tmwf_pkg.sv
// Shared types and constants for the trimuon mass window filter.
`timescale 1ns / 1ps
package tmwf_pkg;

  // Default store depth per charge
  localparam int unsigned MaxMuonsDef = 8;

  // Field widths
  localparam int unsigned IdW   = 25;
  localparam int unsigned StW   = 8;
  localparam int unsigned PtW   = 21;
  localparam int unsigned EtaW  = 14;
  localparam int unsigned MomW  = 22;
  localparam int unsigned MassW = 22;
  localparam int unsigned CfgW  = 25;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned InDataW = 160;
  localparam int unsigned OutDataW = 8;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegTargetId = 3'd0;
  localparam logic [CfgIdxW-1:0] RegPtMin    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegEtaMax   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegStatus   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegMassMin  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegMassMax  = 3'd5;

  // Muon particle code (negative sign is mu plus)
  localparam logic signed [IdW-1:0] MuMinusId = 25'sd13;
  localparam logic signed [IdW-1:0] MuPlusId  = -25'sd13;

  // Triplet side: which store gives the single muon
  localparam logic SideNegSingle = 1'b0;
  localparam logic SidePosSingle = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic load_item;
    logic store_wr;
    logic set_ovf;
    logic issue;
    logic side;
    logic load_out;
    logic clear_event;
  } tmwf_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic mu_neg;
    logic mu_pos;
    logic last;
    logic found;
    logic busy;
    logic out_free;
  } tmwf_stat_t;

endpackage

>>> sv/tmwf_dpath.sv
// Datapath: cuts, muon stores, triplet mass pipeline, flags and output register.
`timescale 1ns / 1ps
module tmwf_dpath
  import tmwf_pkg::*;
#(
  parameter int unsigned MAX_MUONS = MaxMuonsDef,
  localparam int unsigned IW = $clog2(MAX_MUONS),
  localparam int unsigned CW = $clog2(MAX_MUONS + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tmwf_cmd_t            cmd_i,
  output tmwf_stat_t           stat_o,
  input  logic [IW-1:0]        idx_i_i,
  input  logic [IW-1:0]        idx_j_i,
  input  logic [IW-1:0]        idx_k_i,
  output logic [CW-1:0]        neg_cnt_o,
  output logic [CW-1:0]        pos_cnt_o,
  input  logic [InDataW-1:0]   in_data_i,
  input  logic                 in_last_i,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgW-1:0]      cfg_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [OutDataW-1:0]  out_data_o
);

  localparam int unsigned WordW = 4 * MomW;

  // Configuration registers
  logic signed [IdW-1:0] target_q;
  logic [PtW-1:0]        pt_min_q;
  logic [EtaW-1:0]       eta_max_q;
  logic [StW-1:0]        status_q;
  logic [MassW-1:0]      mass_min_q, mass_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q   <= '0;
      pt_min_q   <= '0;
      eta_max_q  <= '1;
      status_q   <= '0;
      mass_min_q <= '0;
      mass_max_q <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegTargetId: target_q   <= cfg_data_i[IdW-1:0];
        RegPtMin:    pt_min_q   <= cfg_data_i[PtW-1:0];
        RegEtaMax:   eta_max_q  <= cfg_data_i[EtaW-1:0];
        RegStatus:   status_q   <= cfg_data_i[StW-1:0];
        RegMassMin:  mass_min_q <= cfg_data_i[MassW-1:0];
        RegMassMax:  mass_max_q <= cfg_data_i[MassW-1:0];
        default: ;
      endcase
    end
  end

  // Item register
  logic signed [IdW-1:0]  id_q;
  logic [StW-1:0]         st_q;
  logic [PtW-1:0]         pt_q;
  logic signed [EtaW-1:0] eta_q;
  logic [WordW-1:0]       mom_q;   // {e, z, y, x}
  logic                   last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      id_q   <= in_data_i[24:0];
      st_q   <= in_data_i[32:25];
      pt_q   <= in_data_i[53:33];
      eta_q  <= in_data_i[67:54];
      mom_q  <= {in_data_i[155:134], in_data_i[133:112], in_data_i[111:90], in_data_i[89:68]};
      last_q <= in_last_i;
    end
  end

  // Particle cuts
  logic signed [IdW:0] id_ext, tg_ext;
  logic [IdW:0]        id_abs, tg_abs;
  logic signed [EtaW:0] eta_ext;
  logic [EtaW:0]        eta_abs;
  logic                 pass;

  always_comb begin
    id_ext  = {id_q[IdW-1], id_q};
    tg_ext  = {target_q[IdW-1], target_q};
    eta_ext = {eta_q[EtaW-1], eta_q};
    id_abs  = id_ext[IdW] ? (~id_ext + 1'b1) : id_ext;
    tg_abs  = tg_ext[IdW] ? (~tg_ext + 1'b1) : tg_ext;
    eta_abs = eta_ext[EtaW] ? (~eta_ext + 1'b1) : eta_ext;
    pass = ((target_q == '0) || (tg_abs == id_abs)) &&
           (pt_q > pt_min_q) &&
           (eta_abs < {1'b0, eta_max_q}) &&
           ((status_q == '0) || (st_q == status_q));
  end

  // Counts and flags
  logic [CW-1:0] neg_cnt_q, pos_cnt_q;
  logic          found_q, ovf_q;
  logic          hit;
  logic          v1_q, v2_q, v3_q, v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neg_cnt_q <= '0;
      pos_cnt_q <= '0;
      found_q   <= 1'b0;
      ovf_q     <= 1'b0;
    end else if (cmd_i.clear_event) begin
      neg_cnt_q <= '0;
      pos_cnt_q <= '0;
      found_q   <= 1'b0;
      ovf_q     <= 1'b0;
    end else begin
      if (cmd_i.store_wr && stat_o.mu_neg) neg_cnt_q <= neg_cnt_q + 1'b1;
      if (cmd_i.store_wr && stat_o.mu_pos) pos_cnt_q <= pos_cnt_q + 1'b1;
      if (cmd_i.set_ovf) ovf_q <= 1'b1;
      if (v4_q && hit) found_q <= 1'b1;
    end
  end

  // Muon stores
  logic [WordW-1:0] neg_mem [MAX_MUONS];
  logic [WordW-1:0] pos_mem [MAX_MUONS];
  logic [WordW-1:0] neg_rd0_q, neg_rd1_q, pos_rd0_q, pos_rd1_q;
  logic [IW-1:0]    neg_a0, pos_a0;

  assign neg_a0 = (cmd_i.side == SideNegSingle) ? idx_i_i : idx_j_i;
  assign pos_a0 = (cmd_i.side == SidePosSingle) ? idx_i_i : idx_j_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_wr && stat_o.mu_neg) neg_mem[neg_cnt_q[IW-1:0]] <= mom_q;
    if (cmd_i.store_wr && stat_o.mu_pos) pos_mem[pos_cnt_q[IW-1:0]] <= mom_q;
    neg_rd0_q <= neg_mem[neg_a0];
    neg_rd1_q <= neg_mem[idx_k_i];
    pos_rd0_q <= pos_mem[pos_a0];
    pos_rd1_q <= pos_mem[idx_k_i];
  end

  // Pipeline valid bits
  logic side1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      side1_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      side1_q <= cmd_i.side;
    end
  end

  // Stage 2: triplet sums
  logic [WordW-1:0] wa, wb1, wb2;
  logic signed [MomW+1:0] sx_d, sy_d, sz_d, sx_q, sy_q, sz_q;
  logic [MomW+1:0]        se_d, se_q;

  always_comb begin
    wa  = (side1_q == SideNegSingle) ? neg_rd0_q : pos_rd0_q;
    wb1 = (side1_q == SideNegSingle) ? pos_rd0_q : neg_rd0_q;
    wb2 = (side1_q == SideNegSingle) ? pos_rd1_q : neg_rd1_q;
    sx_d = {{2{wa[21]}}, wa[21:0]} + {{2{wb1[21]}}, wb1[21:0]} + {{2{wb2[21]}}, wb2[21:0]};
    sy_d = {{2{wa[43]}}, wa[43:22]} + {{2{wb1[43]}}, wb1[43:22]}
         + {{2{wb2[43]}}, wb2[43:22]};
    sz_d = {{2{wa[65]}}, wa[65:44]} + {{2{wb1[65]}}, wb1[65:44]}
         + {{2{wb2[65]}}, wb2[65:44]};
    se_d = {2'b0, wa[87:66]} + {2'b0, wb1[87:66]} + {2'b0, wb2[87:66]};
  end

  always_ff @(posedge clk_i) begin
    sx_q <= sx_d;
    sy_q <= sy_d;
    sz_q <= sz_d;
    se_q <= se_d;
  end

  // Stage 3: squares
  logic signed [2*MomW+3:0] px_sq, py_sq, pz_sq;
  logic [2*MomW+3:0]        pe_sq;
  logic [2*MomW+1:0]        x2_q, y2_q, z2_q;
  logic [2*MomW+3:0]        e2_q;
  logic [2*MassW-1:0]       lo2_q, hi2_q;

  assign px_sq = sx_q * sx_q;
  assign py_sq = sy_q * sy_q;
  assign pz_sq = sz_q * sz_q;
  assign pe_sq = se_q * se_q;

  always_ff @(posedge clk_i) begin
    x2_q  <= px_sq[2*MomW+1:0];
    y2_q  <= py_sq[2*MomW+1:0];
    z2_q  <= pz_sq[2*MomW+1:0];
    e2_q  <= pe_sq;
    lo2_q <= mass_min_q * mass_min_q;
    hi2_q <= mass_max_q * mass_max_q;
  end

  // Stage 4: partial differences
  logic signed [2*MomW+4:0] t1_q;
  logic [2*MomW+2:0]        t2_q;

  always_ff @(posedge clk_i) begin
    t1_q <= $signed({1'b0, e2_q}) - $signed({3'b0, x2_q});
    t2_q <= {1'b0, y2_q} + {1'b0, z2_q};
  end

  // Stage 5: window compare
  logic signed [2*MomW+5:0] m2, lo_ext, hi_ext;
  always_comb begin
    m2     = {t1_q[2*MomW+4], t1_q} - $signed({3'b0, t2_q});
    lo_ext = $signed({6'b0, lo2_q});
    hi_ext = $signed({6'b0, hi2_q});
    hit    = (m2 > lo_ext) && (m2 < hi_ext);
  end

  // Output register
  logic out_valid_q, out_acc_q, out_ovf_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_acc_q <= found_q;
      out_ovf_q <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {6'b0, out_ovf_q, out_acc_q};
  assign neg_cnt_o   = neg_cnt_q;
  assign pos_cnt_o   = pos_cnt_q;

  always_comb begin
    stat_o.mu_neg   = pass && (id_q == MuMinusId);
    stat_o.mu_pos   = pass && (id_q == MuPlusId);
    stat_o.last     = last_q;
    stat_o.found    = found_q;
    stat_o.busy     = v1_q | v2_q | v3_q | v4_q;
    stat_o.out_free = !out_valid_q || out_ready_i;
  end

  // A store is never written past its depth
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.store_wr && stat_o.mu_neg |-> neg_cnt_q < CW'(MAX_MUONS))
    else $error("negative store overrun");
  a_no_overrun_p: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.store_wr && stat_o.mu_pos |-> pos_cnt_q < CW'(MAX_MUONS))
    else $error("positive store overrun");
  // A stalled result transaction holds its data
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(out_data_o))
    else $error("result changed while stalled");

endmodule

>>> sv/tmwf_ctrl.sv
// Controller: item sequencing and triplet index generation.
`timescale 1ns / 1ps
module tmwf_ctrl
  import tmwf_pkg::*;
#(
  parameter int unsigned MAX_MUONS = MaxMuonsDef,
  localparam int unsigned IW = $clog2(MAX_MUONS),
  localparam int unsigned CW = $clog2(MAX_MUONS + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output tmwf_cmd_t     cmd_o,
  input  tmwf_stat_t    stat_i,
  output logic [IW-1:0] idx_i_o,
  output logic [IW-1:0] idx_j_o,
  output logic [IW-1:0] idx_k_o,
  input  logic [CW-1:0] neg_cnt_i,
  input  logic [CW-1:0] pos_cnt_i
);

  typedef enum logic [2:0] {
    StIdle, StCheck, StStart, StSearch, StDrain, StEmit
  } state_e;

  state_e        state_q, state_d;
  logic          side_q, side_d;
  logic [IW-1:0] i_q, i_d, j_q, j_d, k_q, k_d;

  // Store sizes seen from each side
  logic [CW:0] neg_n, pos_n, na, nb, i1, j2, k1;
  logic        side0_ok, side1_ok, full;

  always_comb begin
    neg_n    = {1'b0, neg_cnt_i};
    pos_n    = {1'b0, pos_cnt_i};
    na       = (side_q == SideNegSingle) ? neg_n : pos_n;
    nb       = (side_q == SideNegSingle) ? pos_n : neg_n;
    i1       = (CW+1)'(i_q) + 1'b1;
    j2       = (CW+1)'(j_q) + 2'd2;
    k1       = (CW+1)'(k_q) + 1'b1;
    side0_ok = (neg_n != '0) && (pos_n >= 2);
    side1_ok = (pos_n != '0) && (neg_n >= 2);
    full     = stat_i.mu_neg ? (neg_n == (CW+1)'(MAX_MUONS))
                             : (pos_n == (CW+1)'(MAX_MUONS));
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    side_d  = side_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    cmd_o   = '0;
    cmd_o.side = side_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = StCheck;
        end
      end
      StCheck: begin
        if (stat_i.mu_neg || stat_i.mu_pos) begin
          if (full) begin
            cmd_o.set_ovf = 1'b1;
            state_d = stat_i.last ? StEmit : StIdle;
          end else begin
            cmd_o.store_wr = 1'b1;
            state_d = stat_i.found ? (stat_i.last ? StEmit : StIdle) : StStart;
          end
        end else begin
          state_d = stat_i.last ? StEmit : StIdle;
        end
      end
      StStart: begin
        i_d = '0;
        j_d = '0;
        k_d = IW'(1);
        if (side0_ok) begin
          side_d  = SideNegSingle;
          state_d = StSearch;
        end else if (side1_ok) begin
          side_d  = SidePosSingle;
          state_d = StSearch;
        end else begin
          state_d = StDrain;
        end
      end
      StSearch: begin
        cmd_o.issue = 1'b1;
        if (k1 < nb) begin
          k_d = k1[IW-1:0];
        end else if (j2 < nb) begin
          j_d = j_q + 1'b1;
          k_d = j2[IW-1:0];
        end else if (i1 < na) begin
          i_d = i1[IW-1:0];
          j_d = '0;
          k_d = IW'(1);
        end else if (side_q == SideNegSingle && side1_ok) begin
          side_d = SidePosSingle;
          i_d = '0;
          j_d = '0;
          k_d = IW'(1);
        end else begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        if (!stat_i.busy) state_d = stat_i.last ? StEmit : StIdle;
      end
      StEmit: begin
        if (stat_i.out_free) begin
          cmd_o.load_out    = 1'b1;
          cmd_o.clear_event = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // State and loop counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      side_q  <= SideNegSingle;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      side_q  <= side_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
    end
  end

  assign idx_i_o = i_q;
  assign idx_j_o = j_q;
  assign idx_k_o = k_q;

  // Issued triplets use two distinct entries of the pair store
  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.issue |-> k_q > j_q)
    else $error("pair indexes out of order");
  // Issued indexes stay inside the filled part of the stores
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.issue |-> ((CW+1)'(i_q) < na) && ((CW+1)'(k_q) < nb))
    else $error("triplet index beyond store fill");
  // Results only leave once the mass pipeline is empty
  a_emit_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> !stat_i.busy)
    else $error("result loaded with triplets in flight");
  // New items only enter with no triplet in flight
  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !stat_i.busy)
    else $error("item accepted during search");

endmodule

>>> sv/trimuon_mass_window_filter.sv
// Top level of the trimuon mass window filter.
//
// Particles of an event enter on the s_axis channel, one transaction each,
// with tlast on the event's final particle. A particle that passes the cuts
// with code 13 or -13 is kept in the mu minus or mu plus store. After each
// stored muon, unless the event already has a hit, every triplet of one muon
// with two of the opposite sign is run through a five-stage mass pipeline,
// one triplet a cycle; a triplet hits when its mass squared lies strictly
// between mass_min squared and mass_max squared.
// Each particle is loaded and checked; a stored muon then passes a start state,
// the search if a triplet can be formed, and a drain of the pipeline. A search
// issues T = Nn*Np*(Np-1)/2 + Np*Nn*(Nn-1)/2 triplets over the store fills (up to
// 448 at eight entries each); the event's last particle then loads its result.
// At the last particle one transaction leaves on m_axis with the accepted
// and overflow flags, and the stores and flags clear for the next event.
// The result sits in an output register: the next particle is taken while
// it waits, and only a further result stalls until m_axis_tready is seen.
// Reset empties the stores, clears the flags and loads the register
// defaults; it takes no clearing pass. Registers are written via cfg_we_i.
`timescale 1ns / 1ps
module trimuon_mass_window_filter
  import tmwf_pkg::*;
#(
  parameter int unsigned MAX_MUONS = MaxMuonsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // particle_id, gen_status, pt, eta, mom_x, mom_y, mom_z, energy, zero pad
  input  logic [InDataW-1:0]  s_axis_tdata,
  input  logic                s_axis_tlast,   // last_in_event
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // accepted, store_overflow, zero pad
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_data_i
);

  localparam int unsigned IW = $clog2(MAX_MUONS);
  localparam int unsigned CW = $clog2(MAX_MUONS + 1);

  tmwf_cmd_t     cmd;
  tmwf_stat_t    stat;
  logic [IW-1:0] idx_i, idx_j, idx_k;
  logic [CW-1:0] neg_cnt, pos_cnt;

  tmwf_ctrl #(.MAX_MUONS(MAX_MUONS)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd),
    .stat_i     (stat),
    .idx_i_o    (idx_i),
    .idx_j_o    (idx_j),
    .idx_k_o    (idx_k),
    .neg_cnt_i  (neg_cnt),
    .pos_cnt_i  (pos_cnt)
  );

  tmwf_dpath #(.MAX_MUONS(MAX_MUONS)) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .idx_i_i     (idx_i),
    .idx_j_i     (idx_j),
    .idx_k_i     (idx_k),
    .neg_cnt_o   (neg_cnt),
    .pos_cnt_o   (pos_cnt),
    .in_data_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

>>> bench/tb_trimuon_mass_window_filter.sv
// Self-checking testbench for the trimuon mass window filter.
`timescale 1ns / 1ps
module tb_trimuon_mass_window_filter;
  import tmwf_pkg::*;

  localparam int unsigned StoreDepth = MaxMuonsDef;
  localparam int unsigned WatchdogLimit = 20000;

  typedef struct packed {
    logic signed [IdW-1:0]  pid;
    logic [StW-1:0]         status;
    logic [PtW-1:0]         pt;
    logic signed [EtaW-1:0] eta;
    logic signed [MomW-1:0] px;
    logic signed [MomW-1:0] py;
    logic signed [MomW-1:0] pz;
    logic [MomW-1:0]        e;
    logic                   last;
  } particle_t;

  localparam int unsigned ParticleW = $bits(particle_t);

  typedef struct packed {
    logic accepted;
    logic overflow;
  } verdict_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                s_axis_tlast = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgW-1:0]     cfg_data_i = '0;

  trimuon_mass_window_filter i_dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predictor copy of registers and event state
  longint cut_id, cut_pt, cut_eta, cut_status, win_lo, win_hi;
  longint neg_mom[StoreDepth][4];
  longint pos_mom[StoreDepth][4];
  int     n_neg, n_pos;
  bit     hit_flag, ovf_flag;

  particle_t particle_q[$];
  verdict_t  verdict_q[$];
  int        errors = 0;
  bit        accepted_now;

  // Append a particle to the pending stimulus
  task automatic add_particle(particle_t p);
    particle_q = {particle_q, p};
  endtask

  function automatic bit triplet_hits(longint a[4], longint b[4], longint c[4]);
    longint s[4];
    longint m2;
    for (int i = 0; i < 4; i++) s[i] = a[i] + b[i] + c[i];
    m2 = s[3] * s[3] - s[0] * s[0] - s[1] * s[1] - s[2] * s[2];
    return m2 > win_lo * win_lo && m2 < win_hi * win_hi;
  endfunction

  function automatic bit search_triplets();
    for (int i = 0; i < n_neg; i++)
      for (int j = 0; j < n_pos; j++)
        for (int k = j + 1; k < n_pos; k++)
          if (triplet_hits(neg_mom[i], pos_mom[j], pos_mom[k])) return 1'b1;
    for (int i = 0; i < n_pos; i++)
      for (int j = 0; j < n_neg; j++)
        for (int k = j + 1; k < n_neg; k++)
          if (triplet_hits(pos_mom[i], neg_mom[j], neg_mom[k])) return 1'b1;
    return 1'b0;
  endfunction

  // Advance the event state by one particle; queue a verdict on the last one
  task automatic predict_particle(particle_t p);
    longint pid, aid, aeta, mom[4];
    bit pass, stored;
    verdict_t v;
    pid = p.pid;
    aid = pid < 0 ? -pid : pid;
    aeta = p.eta < 0 ? -longint'(p.eta) : longint'(p.eta);
    mom[0] = p.px; mom[1] = p.py; mom[2] = p.pz; mom[3] = longint'(p.e);
    pass = (cut_id == 0 || (cut_id < 0 ? -cut_id : cut_id) == aid) &&
           longint'(p.pt) > cut_pt && aeta < cut_eta &&
           (cut_status == 0 || longint'(p.status) == cut_status);
    stored = 1'b0;
    if (pass && pid == longint'(MuMinusId)) begin
      if (n_neg < StoreDepth) begin
        neg_mom[n_neg] = mom; n_neg++; stored = 1'b1;
      end else ovf_flag = 1'b1;
    end else if (pass && pid == longint'(MuPlusId)) begin
      if (n_pos < StoreDepth) begin
        pos_mom[n_pos] = mom; n_pos++; stored = 1'b1;
      end else ovf_flag = 1'b1;
    end
    if (stored && !hit_flag && search_triplets()) hit_flag = 1'b1;
    if (p.last) begin
      v.accepted = hit_flag;
      v.overflow = ovf_flag;
      verdict_q = {verdict_q, v};
      n_neg = 0; n_pos = 0; hit_flag = 1'b0; ovf_flag = 1'b0;
    end
  endtask

  function automatic logic [InDataW-1:0] pack_particle(particle_t p);
    return {4'b0, p.e, p.pz, p.py, p.px, p.eta, p.pt, p.status, p.pid};
  endfunction

  // Driver: one particle per transaction with a random gap before each
  int send_gap = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && accepted_now) begin
        void'(particle_q.pop_front());
        send_gap = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0) send_gap = 0;
      end
      if (s_axis_tvalid && !accepted_now) begin
        // hold current transaction
      end else if (send_gap > 0 || particle_q.size() == 0) begin
        s_axis_tvalid <= 1'b0;
        if (send_gap > 0) send_gap--;
      end else begin
        predict_particle(particle_q[0]);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pack_particle(particle_q[0]);
        s_axis_tlast  <= particle_q[0].last;
      end
    end
  end

  always @(posedge clk_i) accepted_now = s_axis_tvalid && s_axis_tready;

  // Receiver stall: redraw a wait count after every result
  int recv_wait = 0;
  always @(negedge clk_i) begin
    if (recv_wait > 0) begin
      recv_wait--;
      m_axis_tready <= 1'b0;
    end else m_axis_tready <= 1'b1;
  end

  // Monitor: compare each result transaction with the oldest verdict
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni) begin
      idle_cycles++;
      if (s_axis_tvalid && s_axis_tready) idle_cycles = 0;
      if (m_axis_tvalid && m_axis_tready) begin
        idle_cycles = 0;
        recv_wait = $urandom_range(0, 8);
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected result, actual %h", $realtime, m_axis_tdata);
          errors++;
        end else begin
          want = verdict_q.pop_front();
          if (m_axis_tdata[0] !== want.accepted) begin
            $display("%0t: accepted expected %b actual %b", $realtime,
                     want.accepted, m_axis_tdata[0]);
            errors++;
          end
          if (m_axis_tdata[1] !== want.overflow) begin
            $display("%0t: overflow expected %b actual %b", $realtime,
                     want.overflow, m_axis_tdata[1]);
            errors++;
          end
          if (m_axis_tdata[OutDataW-1:2] !== '0) begin
            $display("%0t: pad expected 0 actual %h", $realtime,
                     m_axis_tdata[OutDataW-1:2]);
            errors++;
          end
        end
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Stimulus helpers
  function automatic particle_t rand_muon(bit neg, bit last);
    particle_t p;
    int spread;
    spread = $urandom_range(0, 3) == 0 ? 2097151 : 3000;
    p.pid = neg ? MuMinusId : MuPlusId;
    p.status = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'd1;
    p.pt = $urandom_range(0, 3) == 0 ? 21'($urandom) : 21'($urandom_range(0, 60000));
    p.eta = $urandom_range(0, 3) == 0 ? 14'($urandom) : 14'($urandom_range(0, 4000) - 2000);
    p.px = 22'($urandom_range(0, 2 * spread) - spread);
    p.py = 22'($urandom_range(0, 2 * spread) - spread);
    p.pz = 22'($urandom_range(0, 2 * spread) - spread);
    p.e = $urandom_range(0, 7) == 0 ? 22'($urandom) : 22'($urandom_range(0, 20000));
    p.last = last;
    return p;
  endfunction

  function automatic particle_t rand_noise(bit last);
    particle_t p;
    p = particle_t'(ParticleW'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                $urandom}));
    if ($urandom_range(0, 1)) p.pid = 25'($urandom_range(0, 60) - 30);
    p.last = last;
    return p;
  endfunction

  task automatic set_reg(logic [CfgIdxW-1:0] idx, longint val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= CfgW'(val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegTargetId: cut_id = longint'(signed'(IdW'(val)));
      RegPtMin:    cut_pt = val & 64'h1FFFFF;
      RegEtaMax:   cut_eta = val & 64'h3FFF;
      RegStatus:   cut_status = val & 64'hFF;
      RegMassMin:  win_lo = val & 64'h3FFFFF;
      RegMassMax:  win_hi = val & 64'h3FFFFF;
      default: ;
    endcase
  endtask

  // Wait until every particle is taken and every verdict checked, then drain
  task automatic wait_idle();
    while (particle_q.size() != 0 || s_axis_tvalid || verdict_q.size() != 0)
      @(posedge clk_i);
    repeat (500) @(posedge clk_i);
  endtask

  task automatic random_events(int n_items);
    int made, len, kind;
    made = 0;
    while (made < n_items) begin
      len = $urandom_range(1, 20);
      kind = $urandom_range(0, 9);
      for (int i = 0; i < len; i++) begin
        if (kind < 8 && $urandom_range(0, 4) != 0)
          add_particle(rand_muon($urandom_range(0, 1), i == len - 1));
        else add_particle(rand_noise(i == len - 1));
      end
      made += len;
    end
  endtask

  initial begin
    particle_t p;
    cut_id = 0; cut_pt = 0; cut_eta = 16383; cut_status = 0;
    win_lo = 0; win_hi = 4194303;
    n_neg = 0; n_pos = 0; hit_flag = 0; ovf_flag = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // Directed: reset window, simple triplet, extremes, overflow, single item
    p = rand_muon(1, 0); p.px = 0; p.py = 0; p.pz = 0; p.e = 1000; p.pt = 10;
    p.eta = 0; add_particle(p);
    p.pid = MuPlusId; add_particle(p);
    add_particle(p);
    p.last = 1; p.pid = 25'sd11; add_particle(p);
    p = particle_t'('1); p.eta = 14'h2000; p.px = 22'h200000;
    p.last = 1; add_particle(p);
    p = particle_t'('0); p.pid = -25'sd16777215; p.last = 1; add_particle(p);
    for (int i = 0; i < 18; i++) add_particle(rand_muon(i < 9, i == 17));
    wait_idle();

    // Tight cuts and window at extremes
    set_reg(RegTargetId, 13); set_reg(RegPtMin, 100); set_reg(RegEtaMax, 1500);
    set_reg(RegStatus, 1); set_reg(RegMassMin, 500); set_reg(RegMassMax, 30000);
    random_events(150);
    wait_idle();
    set_reg(RegTargetId, -16777215); set_reg(RegPtMin, 2097151); set_reg(RegEtaMax, 0);
    set_reg(RegStatus, 255); set_reg(RegMassMin, 4194303); set_reg(RegMassMax, 0);
    random_events(50);
    wait_idle();
    set_reg(RegTargetId, 16777215); set_reg(RegPtMin, 0); set_reg(RegEtaMax, 16383);
    set_reg(RegStatus, 0); set_reg(RegMassMin, 0); set_reg(RegMassMax, 4194303);
    random_events(50);
    wait_idle();
    set_reg(RegTargetId, -13); set_reg(RegMassMin, 2000); set_reg(RegMassMax, 12000);
    random_events(150);
    wait_idle();
    set_reg(RegTargetId, 0); set_reg(RegMassMin, 0); set_reg(RegMassMax, 9000);
    random_events(200);
    wait_idle();

    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
